[sv/multi_pattern_word_masker_defines.svh]
// Assertion macros used by the checker file of the word masker.
`ifndef MULTI_PATTERN_WORD_MASKER_DEFINES_SVH
`define MULTI_PATTERN_WORD_MASKER_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define MPWM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("word masker check failed");

// Checks that an antecedent implies a consequent in the following cycle.
`define MPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("word masker check failed");

`endif

[sv/mpwm_pkg.sv]
// Shared constants and byte functions of the word masker.
package mpwm_pkg;

  localparam logic [1:0] CMD_PAT_BYTE = 2'd0;
  localparam logic [1:0] CMD_PAT_END  = 2'd1;
  localparam logic [1:0] CMD_TXT_BYTE = 2'd2;
  localparam logic [1:0] CMD_TXT_END  = 2'd3;

  // Case folding: upper case to lower case, printable, tab, LF and CR kept, all else to '.'.
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end else if ((b >= 8'h20 && b <= 8'h7E) || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
      r = b;
    end else begin
      r = 8'h2E;
    end
    return r;
  endfunction

  // Replacement byte for a matched position, picked by the low five pattern bits.
  function automatic logic [7:0] mask_byte(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = "*";   5'd1: r = "&";   5'd2: r = "^";   5'd3: r = "%";
      5'd4: r = "$";   5'd5: r = "#";   5'd6: r = "@";   5'd7: r = "!";
      5'd8: r = "!";   5'd9: r = "@";   5'd10: r = "#";  5'd11: r = "$";
      5'd12: r = "%";  5'd13: r = "^";  5'd14: r = "&";  5'd15: r = "*";
      5'd16: r = "@";  5'd17: r = "$";  5'd18: r = "^";  5'd19: r = "*";
      5'd20: r = "!";  5'd21: r = "#";  5'd22: r = "%";  5'd23: r = "&";
      5'd24: r = "&";  5'd25: r = "%";  5'd26: r = "#";  5'd27: r = "!";
      5'd28: r = "*";  5'd29: r = "^";  5'd30: r = "$";  5'd31: r = "@";
      default: r = "*";
    endcase
    return r;
  endfunction

endpackage

[sv/mpwm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/multi_pattern_word_masker.sv]
// Word masker: pattern beats and text beats are taken while loading; an end-of-text beat
// after stored text starts a pass that first folds each text byte (read, then write), then
// for every pattern length from MAX_PATTERN_LEN down to 1 reads the length of every stored
// pattern; a pattern of that length is scanned over the text, compared byte by byte, and
// each match is masked byte by byte. With censoring off the pass is skipped and the text
// goes straight to the output, where each emitted byte is read, loaded and offered, and
// waits while m_axis_tready is low. The pass is bounded by the single read port of the
// folded-text and pattern memories, which the compare walks one byte at a time. No input
// is taken during the pass or while text is emitted.
module multi_pattern_word_masker #(
  parameter int MAX_TEXT        = 64,
  parameter int MAX_PATTERNS    = 128,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic [1:0] s_axis_tuser,   // cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tlast,
  output logic [0:0] m_axis_tuser,   // overflow
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  localparam int PDEPTH = MAX_PATTERNS * MAX_PATTERN_LEN;
  localparam int AW  = $clog2(PDEPTH);
  localparam int PIW = $clog2(MAX_PATTERNS);
  localparam int PCW = $clog2(MAX_PATTERNS + 1);
  localparam int KW  = $clog2(MAX_PATTERN_LEN);
  localparam int LW  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int TW  = $clog2(MAX_TEXT);
  localparam int CW  = $clog2(MAX_TEXT + 1);
  localparam int SW  = ((CW > LW) ? CW : LW) + 1;
  localparam logic [AW-1:0] PLEN_A = AW'(MAX_PATTERN_LEN);

  typedef enum logic [11:0] {
    S_LOAD    = 12'b000000000001,
    S_FOLD_RD = 12'b000000000010,
    S_FOLD_WR = 12'b000000000100,
    S_LEN_RD  = 12'b000000001000,
    S_LEN_CHK = 12'b000000010000,
    S_SCAN    = 12'b000000100000,
    S_CMP     = 12'b000001000000,
    S_MRD     = 12'b000010000000,
    S_MWR     = 12'b000100000000,
    S_EMIT_RD = 12'b001000000000,
    S_EMIT_LD = 12'b010000000000,
    S_EMIT    = 12'b100000000000
  } state_t;

  state_t          state;
  logic            censor;
  logic [PCW-1:0]  pcount;
  logic [LW-1:0]   partial;
  logic            too_long;
  logic [CW-1:0]   tlen;
  logic            ovf;
  logic [LW-1:0]   len;
  logic [PCW-1:0]  pidx;
  logic [CW-1:0]   pos;
  logic [KW-1:0]   k;
  logic [CW-1:0]   epos;
  logic [7:0]      out_data;
  logic            out_last;
  logic            out_ovf;

  logic            pat_we;
  logic [AW-1:0]   pat_waddr, pat_raddr;
  logic [7:0]      pat_rd;
  logic            len_we;
  logic [LW-1:0]   len_rd;
  logic            txt_we;
  logic [TW-1:0]   txt_waddr, txt_raddr;
  logic [7:0]      txt_wdata, txt_rd;
  logic            fld_we;
  logic [TW-1:0]   fld_waddr;
  logic [7:0]      fld_wdata, fld_rd;

  logic            in_beat;
  logic [CW-1:0]   pk;
  logic            fits;
  logic            k_last;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = (state == S_EMIT);
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;

  assign pk     = pos + CW'(k);
  assign fits   = (SW'(pos) + SW'(len)) <= SW'(tlen);
  assign k_last = (LW'(k) + LW'(1)) == len;

  assign pat_we    = in_beat && s_axis_tuser == mpwm_pkg::CMD_PAT_BYTE &&
                     partial < LW'(MAX_PATTERN_LEN) && pcount < PCW'(MAX_PATTERNS);
  assign pat_waddr = AW'(pcount[PIW-1:0]) * PLEN_A + AW'(partial[KW-1:0]);
  assign pat_raddr = AW'(pidx[PIW-1:0]) * PLEN_A + AW'(k);
  assign len_we    = in_beat && s_axis_tuser == mpwm_pkg::CMD_PAT_END &&
                     partial != '0 && !too_long && pcount < PCW'(MAX_PATTERNS);

  always_comb begin
    txt_we    = 1'b0;
    txt_waddr = tlen[TW-1:0];
    txt_wdata = s_axis_tdata;
    fld_we    = 1'b0;
    fld_waddr = pos[TW-1:0];
    fld_wdata = mpwm_pkg::fold_byte(txt_rd);
    txt_raddr = (state == S_LOAD || state == S_EMIT_RD || state == S_EMIT_LD ||
                 state == S_EMIT) ? epos[TW-1:0] : pos[TW-1:0];
    if (in_beat && s_axis_tuser == mpwm_pkg::CMD_TXT_BYTE && tlen < CW'(MAX_TEXT)) begin
      txt_we = 1'b1;
    end
    if (state == S_FOLD_WR) begin
      fld_we = 1'b1;
    end
    if (state == S_MWR) begin
      txt_we    = 1'b1;
      txt_waddr = pk[TW-1:0];
      txt_wdata = mpwm_pkg::mask_byte(pat_rd[4:0]);
      fld_we    = 1'b1;
      fld_waddr = pk[TW-1:0];
      fld_wdata = mpwm_pkg::mask_byte(pat_rd[4:0]);
    end
  end

  mpwm_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_pat_ram (
    .clk(clk), .wr_en(pat_we), .wr_addr(pat_waddr), .wr_data(s_axis_tdata),
    .rd_addr(pat_raddr), .rd_data(pat_rd)
  );

  mpwm_ram #(.WIDTH(LW), .DEPTH(MAX_PATTERNS)) u_len_ram (
    .clk(clk), .wr_en(len_we), .wr_addr(pcount[PIW-1:0]), .wr_data(partial),
    .rd_addr(pidx[PIW-1:0]), .rd_data(len_rd)
  );

  mpwm_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_txt_ram (
    .clk(clk), .wr_en(txt_we), .wr_addr(txt_waddr), .wr_data(txt_wdata),
    .rd_addr(txt_raddr), .rd_data(txt_rd)
  );

  mpwm_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_fld_ram (
    .clk(clk), .wr_en(fld_we), .wr_addr(fld_waddr), .wr_data(fld_wdata),
    .rd_addr(pk[TW-1:0]), .rd_data(fld_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      censor   <= 1'b1;
      pcount   <= '0;
      partial  <= '0;
      too_long <= 1'b0;
      tlen     <= '0;
      ovf      <= 1'b0;
      len      <= '0;
      pidx     <= '0;
      pos      <= '0;
      k        <= '0;
      epos     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        censor <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (in_beat) begin
            case (s_axis_tuser)
              mpwm_pkg::CMD_PAT_BYTE: begin
                if (partial >= LW'(MAX_PATTERN_LEN)) begin
                  too_long <= 1'b1;
                end else begin
                  partial <= partial + LW'(1);
                end
              end
              mpwm_pkg::CMD_PAT_END: begin
                if (len_we) begin
                  pcount <= pcount + PCW'(1);
                end
                partial  <= '0;
                too_long <= 1'b0;
              end
              mpwm_pkg::CMD_TXT_BYTE: begin
                if (tlen < CW'(MAX_TEXT)) begin
                  tlen <= tlen + CW'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              default: begin
                pos  <= '0;
                epos <= '0;
                if (tlen == '0) begin
                  ovf <= 1'b0;
                end else if (censor) begin
                  state <= S_FOLD_RD;
                end else begin
                  state <= S_EMIT_RD;
                end
              end
            endcase
          end
        end
        S_FOLD_RD: state <= S_FOLD_WR;
        S_FOLD_WR: begin
          if (pos + CW'(1) == tlen) begin
            len   <= LW'(MAX_PATTERN_LEN);
            pidx  <= '0;
            state <= S_LEN_RD;
          end else begin
            pos   <= pos + CW'(1);
            state <= S_FOLD_RD;
          end
        end
        S_LEN_RD: begin
          if (pidx == pcount) begin
            if (len == LW'(1)) begin
              state <= S_EMIT_RD;
            end else begin
              len  <= len - LW'(1);
              pidx <= '0;
            end
          end else begin
            state <= S_LEN_CHK;
          end
        end
        S_LEN_CHK: begin
          pos <= '0;
          k   <= '0;
          if (len_rd == len) begin
            state <= S_SCAN;
          end else begin
            pidx  <= pidx + PCW'(1);
            state <= S_LEN_RD;
          end
        end
        S_SCAN: begin
          if (fits) begin
            state <= S_CMP;
          end else begin
            pidx  <= pidx + PCW'(1);
            state <= S_LEN_RD;
          end
        end
        S_CMP: begin
          if (fld_rd != pat_rd) begin
            pos   <= pos + CW'(1);
            k     <= '0;
            state <= S_SCAN;
          end else if (k_last) begin
            k     <= '0;
            state <= S_MRD;
          end else begin
            k     <= k + KW'(1);
            state <= S_SCAN;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (k_last) begin
            pos   <= pos + CW'(len);
            k     <= '0;
            state <= S_SCAN;
          end else begin
            k     <= k + KW'(1);
            state <= S_MRD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: state <= S_EMIT;
        S_EMIT: begin
          if (m_axis_tready) begin
            if (out_last) begin
              tlen  <= '0;
              ovf   <= 1'b0;
              epos  <= '0;
              state <= S_LOAD;
            end else begin
              epos  <= epos + CW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Output beat registers are loaded once the text read returns.
  always_ff @(posedge clk) begin
    if (state == S_EMIT_LD) begin
      out_data <= txt_rd;
      out_last <= (epos + CW'(1)) == tlen;
      out_ovf  <= ovf;
    end
  end

endmodule

[sv/mpwm_checker.sv]
// Port-level checker of the word masker and its bind.
`include "multi_pattern_word_masker_defines.svh"

module mpwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic       m_axis_tlast,
  input logic [7:0] m_axis_tdata
);

  // Input and output are never open in the same cycle.
  `MPWM_ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready)
  // A stalled output beat stays offered with the same byte.
  `MPWM_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // The final beat of a message ends the output burst.
  `MPWM_ASSERT_NEXT(a_last_ends, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
  // Input stays closed between beats of one message.
  `MPWM_ASSERT_NEXT(a_mid_closed, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready)

endmodule

bind multi_pattern_word_masker mpwm_checker u_mpwm_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
);
